@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Used by tcw_front, tcw_back and text_console_writer; no dependencies.
package tcw_pkg;

    // Default screen geometry limits
    localparam int DEF_MAX_COLUMNS = 80;
    localparam int DEF_MAX_ROWS    = 25;

    // Configuration register indexes and reset values
    localparam logic       CFG_COLUMNS    = 1'b0;
    localparam logic       CFG_ROWS       = 1'b1;
    localparam logic [6:0] COLUMNS_RESET  = 7'd80;
    localparam logic [4:0] ROWS_RESET     = 5'd25;

    // Cell constants
    localparam logic [15:0] ATTR_MASK    = 16'hff00;
    localparam logic [15:0] ATTR_SET     = 16'h0f00;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0a;

    // Command codes on the input tuser
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Classified operation kinds
    localparam logic [1:0] KIND_IGNORE  = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } tcw_op_t;

endpackage

@@ rtl/core/tcw_front.sv @@
// Front end: accepts input words, classifies them and queues the operations.
// Depends on tcw_pkg for the operation struct, kind codes and queue depth.
module tcw_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clearing,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,   // character[7:0], read_row[12:8], read_column[19:13]
    input  logic            s_tuser,   // command[0]
    output logic            q_valid,
    output tcw_pkg::tcw_op_t q_op,
    input  logic            q_pop
);

    localparam int QAw = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
    localparam int QCw = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

    tcw_pkg::tcw_op_t entry_reg [tcw_pkg::QUEUE_DEPTH];
    logic [QAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCw-1:0]   count_reg, count_next;
    tcw_pkg::tcw_op_t op_in;
    logic             push;

    // Classify the incoming word
    always_comb begin
        op_in.ch          = s_tdata[7:0];
        op_in.read_row    = s_tdata[12:8];
        op_in.read_column = s_tdata[19:13];
        if (s_tuser == tcw_pkg::CMD_READ) begin
            op_in.kind = tcw_pkg::KIND_READ;
        end else if (s_tdata[7:0] == tcw_pkg::NEWLINE_CHAR) begin
            op_in.kind = tcw_pkg::KIND_NEWLINE;
        end else if (s_tdata[7:0] == 8'h00) begin
            op_in.kind = tcw_pkg::KIND_IGNORE;
        end else begin
            op_in.kind = tcw_pkg::KIND_CHAR;
        end
    end

    assign s_tready = (count_reg != QCw'(tcw_pkg::QUEUE_DEPTH)) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_op     = entry_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAw'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = (rd_ptr_reg == QAw'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && (q_pop && q_valid)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the queued operation
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// Back end: screen memory, cursor, scroll sweep and the result register.
// Depends on tcw_pkg for the operation struct, kinds and cell constants.
module tcw_back #(
    parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [6:0]       cfg_columns,
    input  logic [4:0]       cfg_rows,
    output logic             clearing,
    input  logic             q_valid,
    input  tcw_pkg::tcw_op_t q_op,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);

    localparam int CellDepth = MAX_COLUMNS * MAX_ROWS;
    localparam int Aw        = (CellDepth > 1) ? $clog2(CellDepth) : 1;

    localparam logic [2:0] S_CLEAR      = 3'd0;
    localparam logic [2:0] S_IDLE       = 3'd1;
    localparam logic [2:0] S_RDATA      = 3'd2;
    localparam logic [2:0] S_RMW        = 3'd3;
    localparam logic [2:0] S_SCROLL     = 3'd4;
    localparam logic [2:0] S_SCROLL_END = 3'd5;
    localparam logic [2:0] S_HOLD       = 3'd6;

    logic [15:0] mem [CellDepth];
    logic [15:0] rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [Aw-1:0] clr_ptr_reg, clr_ptr_next;
    logic [6:0]    cur_col_reg, cur_col_next;
    logic [4:0]    cur_row_reg, cur_row_next;
    logic [7:0]    ch_reg, ch_next;
    logic [Aw-1:0] addr_reg, addr_next;
    logic          inrange_reg, inrange_next;
    logic [Aw-1:0] j_reg, j_next;
    logic [Aw-1:0] upper_reg, upper_next;
    logic [Aw-1:0] total_reg, total_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [Aw-1:0] pend_addr_reg, pend_addr_next;
    logic          pend_blank_reg, pend_blank_next;
    logic [15:0]   hold_cell_reg, hold_cell_next;
    logic          hold_scr_reg, hold_scr_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    logic          mem_we;
    logic [Aw-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [Aw-1:0] mem_ra;

    logic [6:0]    ncol;
    logic [4:0]    nrow;
    logic [6:0]    sat_col;
    logic [4:0]    sat_row;
    logic [11:0]   geo_total;
    logic [11:0]   cur_addr;
    logic [11:0]   rd_addr;
    logic          out_free;
    logic          fin;
    logic [15:0]   fin_cell;
    logic          fin_scr;

    // Clamp geometry and the cursor to the active screen
    always_comb begin
        if (cfg_columns == 7'd0) begin
            ncol = 7'd1;
        end else if (int'(cfg_columns) > MAX_COLUMNS) begin
            ncol = 7'(MAX_COLUMNS);
        end else begin
            ncol = cfg_columns;
        end
        if (cfg_rows == 5'd0) begin
            nrow = 5'd1;
        end else if (int'(cfg_rows) > MAX_ROWS) begin
            nrow = 5'(MAX_ROWS);
        end else begin
            nrow = cfg_rows;
        end
        sat_col   = (cur_col_reg >= ncol) ? ncol - 7'd1 : cur_col_reg;
        sat_row   = (cur_row_reg >= nrow) ? nrow - 5'd1 : cur_row_reg;
        geo_total = 12'(nrow) * 12'(ncol);
        cur_addr  = 12'(sat_row) * 12'(ncol) + 12'(sat_col);
        rd_addr   = 12'(q_op.read_row) * 12'(ncol) + 12'(q_op.read_column);
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign clearing = (state_reg == S_CLEAR);
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequence one operation at a time
    always_comb begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        ch_next         = ch_reg;
        addr_next       = addr_reg;
        inrange_next    = inrange_reg;
        j_next          = j_reg;
        upper_next      = upper_reg;
        total_next      = total_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        hold_cell_next  = hold_cell_reg;
        hold_scr_next   = hold_scr_reg;
        mem_we          = 1'b0;
        mem_wa          = addr_reg;
        mem_wd          = 16'h0000;
        mem_ra          = addr_reg;
        fin             = 1'b0;
        fin_cell        = 16'h0000;
        fin_scr         = 1'b0;

        // Write back the pending scroll word
        if (pend_valid_reg) begin
            mem_we = 1'b1;
            mem_wa = pend_addr_reg;
            mem_wd = pend_blank_reg ? ((rd_data_reg & tcw_pkg::ATTR_MASK) |
                                       {8'h00, tcw_pkg::BLANK_CHAR})
                                    : rd_data_reg;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_wa       = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == Aw'(CellDepth - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    cur_col_next = sat_col;
                    cur_row_next = sat_row;
                    ch_next      = q_op.ch;
                    upper_next   = Aw'(geo_total - 12'(ncol));
                    total_next   = Aw'(geo_total);
                    j_next       = '0;
                    unique case (q_op.kind)
                        tcw_pkg::KIND_READ: begin
                            inrange_next = (q_op.read_row < nrow) && (q_op.read_column < ncol);
                            addr_next    = Aw'(rd_addr);
                            mem_ra       = Aw'(rd_addr);
                            state_next   = S_RDATA;
                        end
                        tcw_pkg::KIND_CHAR: begin
                            addr_next  = Aw'(cur_addr);
                            mem_ra     = Aw'(cur_addr);
                            state_next = S_RMW;
                        end
                        tcw_pkg::KIND_NEWLINE: begin
                            cur_col_next = 7'd0;
                            if (sat_row + 5'd1 >= nrow) begin
                                cur_row_next = nrow - 5'd1;
                                state_next   = S_SCROLL;
                            end else begin
                                cur_row_next = sat_row + 5'd1;
                                fin          = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_RDATA: begin
                fin      = 1'b1;
                fin_cell = inrange_reg ? rd_data_reg : 16'h0000;
            end
            S_RMW: begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = (rd_data_reg & tcw_pkg::ATTR_MASK) | tcw_pkg::ATTR_SET |
                         {8'h00, ch_reg};
                if (cur_col_reg + 7'd1 >= ncol) begin
                    cur_col_next = 7'd0;
                    if (cur_row_reg + 5'd1 >= nrow) begin
                        cur_row_next = nrow - 5'd1;
                        state_next   = S_SCROLL;
                    end else begin
                        cur_row_next = cur_row_reg + 5'd1;
                        fin          = 1'b1;
                    end
                end else begin
                    cur_col_next = cur_col_reg + 7'd1;
                    fin          = 1'b1;
                end
            end
            S_SCROLL: begin
                // Read the source of cell j; its write lands next cycle
                mem_ra          = (j_reg < upper_reg) ? j_reg + Aw'(ncol) : j_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = j_reg;
                pend_blank_next = (j_reg >= upper_reg);
                j_next          = j_reg + 1'b1;
                if (j_reg == total_reg - 1'b1) begin
                    state_next = S_SCROLL_END;
                end
            end
            S_SCROLL_END: begin
                fin     = 1'b1;
                fin_scr = 1'b1;
            end
            S_HOLD: begin
                fin      = 1'b1;
                fin_cell = hold_cell_reg;
                fin_scr  = hold_scr_reg;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Drain the output register, then load a finished result or hold it
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (fin) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {3'b000, fin_scr, cur_row_next, cur_col_next, fin_cell};
                state_next    = S_IDLE;
            end else begin
                hold_cell_next = fin_cell;
                hold_scr_next  = fin_scr;
                state_next     = S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_ptr_reg    <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg         <= ch_next;
        addr_reg       <= addr_next;
        inrange_reg    <= inrange_next;
        j_reg          <= j_next;
        upper_reg      <= upper_next;
        total_reg      <= total_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
        hold_cell_reg  <= hold_cell_next;
        hold_scr_reg   <= hold_scr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Screen memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer top level: configuration registers, front and back ends.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
// Character-cell text console with a 16-bit screen memory (attribute high byte,
// character low byte) and a cursor. Every input word gives exactly one result
// word. After reset the block clears all MAX_COLUMNS*MAX_ROWS cells of the screen
// memory, one cell a cycle, and holds s_tready low until that is done.
// A newline with no scroll or an ignored character (zero) finishes from the idle
// state; a read waits on the registered read of the screen memory, and a plain
// character on that read and then the write back. A scroll walks the active
// screen through that memory, one cell a cycle. A two-word queue sits between
// input and the engine, and the result register lets the engine go on while a
// result waits. Write columns and rows only while the block is idle.
module text_console_writer #(
    parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // character[7:0], read_row[12:8], read_column[19:13]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cell_word[15:0], cursor_column[22:16],
                                   // cursor_row[27:23], scrolled[28]
);

    logic [6:0]       columns_reg;
    logic [4:0]       rows_reg;
    logic             clearing;
    logic             q_valid;
    logic             q_pop;
    tcw_pkg::tcw_op_t q_op;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= tcw_pkg::COLUMNS_RESET;
            rows_reg    <= tcw_pkg::ROWS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcw_pkg::CFG_COLUMNS: columns_reg <= cfg_data;
                tcw_pkg::CFG_ROWS:    rows_reg    <= cfg_data[4:0];
                default:              columns_reg <= columns_reg;
            endcase
        end
    end

    tcw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clearing (clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop)
    );

    tcw_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_columns (columns_reg),
        .cfg_rows    (rows_reg),
        .clearing    (clearing),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
